@@ hw/rtl/bitplane_gradient_abs_sum_unit_defines.svh @@
// Assertion macros shared by the gradient block RTL.
`ifndef BITPLANE_GRADIENT_ABS_SUM_UNIT_DEFINES_SVH
`define BITPLANE_GRADIENT_ABS_SUM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define BGAS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Consequent holds in the same cycle as the antecedent.
`define BGAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define BGAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BGAS_ASSERT(lbl, cond, msg)
`define BGAS_ASSERT_IMP(lbl, ante, cons, msg)
`define BGAS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/bgas_pkg.sv @@
// Shared constants and types of the bit-plane gradient block.
package bgas_pkg;

  localparam int MAX_WIDTH        = 1024;
  localparam int PLANE_COUNT      = 8;
  localparam int NUM_INPUT_PLANES = 8;

  localparam int PIX_W      = 16;
  localparam int ROW_W      = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int OUT_COL_W  = 10;
  localparam int SUM_W      = 20;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int MIN_DIM   = 3;
  localparam int FW_RESET  = 640;
  localparam int FH_RESET  = 480;
  localparam int LAST_COL_RESET = (FW_RESET > MAX_WIDTH ? MAX_WIDTH : FW_RESET) - 1;
  localparam int LAST_ROW_RESET = FH_RESET - 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 8'd0,
    CFG_FRAME_HEIGHT = 8'd1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [PLANE_COUNT-1:0] planes_t;

  // One line-store entry: the two rows above the current one for a column.
  typedef struct packed {
    planes_t upper;
    planes_t middle;
  } line_t;

  // Absolute differences of one interior pixel plus its position.
  typedef struct packed {
    planes_t           dx;
    planes_t           dy;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } job_t;

endpackage

@@ hw/rtl/bgas_if.sv @@
// Stream and configuration channel interfaces of the gradient block.
interface bgas_pix_if;
  logic                 valid;
  logic                 ready;
  logic [bgas_pkg::PIX_W-1:0] plane_0;
  logic [bgas_pkg::PIX_W-1:0] plane_1;
  logic [bgas_pkg::PIX_W-1:0] plane_2;
  logic [bgas_pkg::PIX_W-1:0] plane_3;
  logic [bgas_pkg::PIX_W-1:0] plane_4;
  logic [bgas_pkg::PIX_W-1:0] plane_5;
  logic [bgas_pkg::PIX_W-1:0] plane_6;
  logic [bgas_pkg::PIX_W-1:0] plane_7;
  modport source (output valid, plane_0, plane_1, plane_2, plane_3,
                  plane_4, plane_5, plane_6, plane_7, input ready);
  modport sink   (input valid, plane_0, plane_1, plane_2, plane_3,
                  plane_4, plane_5, plane_6, plane_7, output ready);
endinterface

interface bgas_res_if;
  logic                           valid;
  logic                           ready;
  logic [bgas_pkg::SUM_W-1:0]     gradient_sum;
  logic [bgas_pkg::ROW_W-1:0]     out_row;
  logic [bgas_pkg::OUT_COL_W-1:0] out_col;
  modport source (output valid, gradient_sum, out_row, out_col, input ready);
  modport sink   (input valid, gradient_sum, out_row, out_col, output ready);
endinterface

interface bgas_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bgas_pkg::CFG_IDX_W-1:0]  index;
  logic [bgas_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bgas_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
module bgas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bgas_front.sv @@
// Front end: raster counters, configuration, line store and difference terms.
`include "bitplane_gradient_abs_sum_unit_defines.svh"

module bgas_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  bgas_pix_if.sink        pix_i,
  bgas_cfg_if.sink        cfg_i,
  input  logic            pop_i,
  output logic            push_o,
  output bgas_pkg::job_t  job_o
);

  localparam int LINE_W = $bits(bgas_pkg::line_t);

  logic                          accept;
  logic                          emit_now;
  logic                          cfg_wr;
  logic [bgas_pkg::COL_W-1:0]    col_q, col_d;
  logic [bgas_pkg::ROW_W-1:0]    row_q, row_d;
  logic [bgas_pkg::COL_W-1:0]    last_col_q, last_col_d;
  logic [bgas_pkg::ROW_W-1:0]    last_row_q, last_row_d;
  logic [bgas_pkg::COL_W-1:0]    wr_last_col;
  logic [bgas_pkg::ROW_W-1:0]    wr_last_row;
  logic [bgas_pkg::FW_W-1:0]     wr_w;
  logic [bgas_pkg::FH_W-1:0]     wr_h;
  logic [bgas_pkg::QCNT_W-1:0]   reserved_q, reserved_d;

  bgas_pkg::pix_t [bgas_pkg::NUM_INPUT_PLANES-1:0] in_all;
  bgas_pkg::planes_t             cur;

  logic                          s1_valid_q;
  logic                          s1_emit_q;
  bgas_pkg::planes_t             s1_cur_q;
  logic [bgas_pkg::COL_W-1:0]    s1_col_q;
  logic [bgas_pkg::ROW_W-1:0]    s1_row_q;

  logic [LINE_W-1:0]             ram_rdata;
  bgas_pkg::line_t               rd_line;
  bgas_pkg::line_t               wr_line;

  bgas_pkg::planes_t             mid_d1_q, mid_d2_q, up_d1_q, prev_q;
  bgas_pkg::job_t                job_d, job_q;
  logic                          s2_valid_q;

  // Input channel
  assign in_all = {pix_i.plane_7, pix_i.plane_6, pix_i.plane_5, pix_i.plane_4,
                   pix_i.plane_3, pix_i.plane_2, pix_i.plane_1, pix_i.plane_0};

  always_comb begin
    for (int p = 0; p < bgas_pkg::PLANE_COUNT; p++) begin
      cur[p] = in_all[p];
    end
  end

  // An interior result needs two rows and two columns of history.
  assign emit_now    = (row_q >= bgas_pkg::ROW_W'(2)) && (col_q >= bgas_pkg::COL_W'(2));
  assign pix_i.ready = !emit_now || (reserved_q < bgas_pkg::QCNT_W'(bgas_pkg::QDEPTH));
  assign accept      = pix_i.valid && pix_i.ready;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  // Clamp written dimensions to their legal range, kept as last index
  assign wr_w = cfg_i.data[bgas_pkg::FW_W-1:0];
  assign wr_h = cfg_i.data[bgas_pkg::FH_W-1:0];

  always_comb begin
    if (wr_w < bgas_pkg::FW_W'(bgas_pkg::MIN_DIM)) begin
      wr_last_col = bgas_pkg::COL_W'(bgas_pkg::MIN_DIM - 1);
    end else if (32'(wr_w) > 32'(bgas_pkg::MAX_WIDTH)) begin
      wr_last_col = bgas_pkg::COL_W'(bgas_pkg::MAX_WIDTH - 1);
    end else begin
      wr_last_col = bgas_pkg::COL_W'(wr_w - bgas_pkg::FW_W'(1));
    end
    if (wr_h < bgas_pkg::FH_W'(bgas_pkg::MIN_DIM)) begin
      wr_last_row = bgas_pkg::ROW_W'(bgas_pkg::MIN_DIM - 1);
    end else begin
      wr_last_row = bgas_pkg::ROW_W'(wr_h - bgas_pkg::FH_W'(1));
    end
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    if (cfg_wr) begin
      case (bgas_pkg::cfg_reg_e'(cfg_i.index))
        bgas_pkg::CFG_FRAME_WIDTH: begin
          last_col_d = wr_last_col;
          col_d      = '0;
          row_d      = '0;
        end
        bgas_pkg::CFG_FRAME_HEIGHT: begin
          last_row_d = wr_last_row;
          col_d      = '0;
          row_d      = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_q == last_col_q) begin
        col_d = '0;
        row_d = (row_q == last_row_q) ? '0 : row_q + bgas_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + bgas_pkg::COL_W'(1);
      end
    end
  end

  // Slots held from acceptance of an emitting word until the back end pops it
  assign reserved_d = reserved_q + bgas_pkg::QCNT_W'(accept && emit_now)
                    - bgas_pkg::QCNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      last_col_q <= bgas_pkg::COL_W'(bgas_pkg::LAST_COL_RESET);
      last_row_q <= bgas_pkg::ROW_W'(bgas_pkg::LAST_ROW_RESET);
      reserved_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      reserved_q <= reserved_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  // Line store: read the column on accept, write it back in the next cycle
  bgas_ram #(
    .WIDTH (LINE_W),
    .DEPTH (bgas_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (wr_line),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign rd_line        = bgas_pkg::line_t'(ram_rdata);
  assign wr_line.upper  = rd_line.middle;
  assign wr_line.middle = s1_cur_q;

  // Left from two columns back, top from the row above the previous column
  always_comb begin
    for (int p = 0; p < bgas_pkg::PLANE_COUNT; p++) begin
      job_d.dx[p] = (rd_line.middle[p] > mid_d2_q[p]) ? rd_line.middle[p] - mid_d2_q[p]
                                                      : mid_d2_q[p] - rd_line.middle[p];
      job_d.dy[p] = (prev_q[p] > up_d1_q[p]) ? prev_q[p] - up_d1_q[p]
                                             : up_d1_q[p] - prev_q[p];
    end
    job_d.row = s1_row_q - bgas_pkg::ROW_W'(1);
    job_d.col = s1_col_q - bgas_pkg::COL_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q  <= cur;
      s1_emit_q <= emit_now;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
    end
    if (s1_valid_q) begin
      mid_d1_q <= rd_line.middle;
      mid_d2_q <= mid_d1_q;
      up_d1_q  <= rd_line.upper;
      prev_q   <= s1_cur_q;
      job_q    <= job_d;
    end
  end

  assign push_o = s2_valid_q;
  assign job_o  = job_q;

  `BGAS_ASSERT(a_reserved_bound, reserved_q <= bgas_pkg::QCNT_W'(bgas_pkg::QDEPTH), "reserved slots exceed queue depth")
  `BGAS_ASSERT(a_col_in_row, col_q <= last_col_q, "column counter past end of row")
  `BGAS_ASSERT_IMP(a_push_reserved, s2_valid_q, reserved_q != '0, "push without a reserved slot")

endmodule

@@ hw/rtl/bgas_queue.sv @@
// Short queue of difference jobs between the front and back ends.
`include "bitplane_gradient_abs_sum_unit_defines.svh"

module bgas_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bgas_pkg::job_t  job_i,
  output logic            valid_o,
  output bgas_pkg::job_t  job_o,
  input  logic            pop_i
);

  bgas_pkg::job_t               mem_q [bgas_pkg::QDEPTH];
  logic [bgas_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bgas_pkg::QCNT_W-1:0]  count_q;

  function automatic logic [bgas_pkg::QPTR_W-1:0] ptr_inc(
    input logic [bgas_pkg::QPTR_W-1:0] ptr
  );
    return (ptr == bgas_pkg::QPTR_W'(bgas_pkg::QDEPTH - 1)) ? '0
                                                            : ptr + bgas_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      count_q <= count_q + bgas_pkg::QCNT_W'(push_i) - bgas_pkg::QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  `BGAS_ASSERT(a_no_overflow, !(push_i && (count_q == bgas_pkg::QCNT_W'(bgas_pkg::QDEPTH))), "push into full queue")
  `BGAS_ASSERT_IMP(a_pop_nonempty, pop_i, count_q != '0, "pop from empty queue")

endmodule

@@ hw/rtl/bgas_back.sv @@
// Back end: adds the difference terms and drives the result channel.
module bgas_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  bgas_pkg::job_t  job_i,
  output logic            q_pop_o,
  bgas_res_if.source      res_o
);

  logic                        a_valid_q, b_valid_q;
  logic                        a_adv, b_adv;
  logic [bgas_pkg::PIX_W:0]    a_sum_q [bgas_pkg::PLANE_COUNT];
  logic [bgas_pkg::ROW_W-1:0]  a_row_q, b_row_q;
  logic [bgas_pkg::COL_W-1:0]  a_col_q, b_col_q;
  logic [bgas_pkg::SUM_W-1:0]  total, b_sum_q;

  // Advance each stage when it is empty or its successor moves
  assign b_adv   = !b_valid_q || res_o.ready;
  assign a_adv   = !a_valid_q || b_adv;
  assign q_pop_o = q_valid_i && a_adv;

  always_comb begin
    total = '0;
    for (int p = 0; p < bgas_pkg::PLANE_COUNT; p++) begin
      total = total + bgas_pkg::SUM_W'(a_sum_q[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= q_valid_i;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int p = 0; p < bgas_pkg::PLANE_COUNT; p++) begin
        a_sum_q[p] <= {1'b0, job_i.dx[p]} + {1'b0, job_i.dy[p]};
      end
      a_row_q <= job_i.row;
      a_col_q <= job_i.col;
    end
    if (b_adv && a_valid_q) begin
      b_sum_q <= total;
      b_row_q <= a_row_q;
      b_col_q <= a_col_q;
    end
  end

  assign res_o.valid        = b_valid_q;
  assign res_o.gradient_sum = b_sum_q;
  assign res_o.out_row      = b_row_q;
  assign res_o.out_col      = bgas_pkg::OUT_COL_W'(b_col_q);

endmodule

@@ hw/rtl/bitplane_gradient_abs_sum_unit.sv @@
// Top level of the bit-plane L1 gradient block.
//
// Pixels enter on pix_i in raster order, one word per pixel with eight
// 16-bit plane values. For every interior pixel (row r, column c) one word
// leaves on res_o with the sum over planes of the absolute horizontal and
// vertical central differences, plus r and c. Border pixels give no word.
// The word for (r, c) is formed when pixel (r+1, c+1) is taken.
// Throughput: one pixel per clock while pix_i.ready is high. A result
// reaches res_o through the line store read, the difference stage, the
// job queue and two adder stages.
// cfg_i writes frame_width (index 0) and frame_height (index 1); ready is
// always high and a write restarts the frame at row 0, column 0.
// Write configuration only while the block is idle.
// Reset clears the counters and sets a 640 x 480 frame; the line store is
// not cleared, as only entries written in the current frame are read.
// When res_o stalls, a 4-entry job queue absorbs words in flight; pix_i
// drops ready only for pixels that would produce a word with no slot left.
module bitplane_gradient_abs_sum_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgas_pix_if.sink    pix_i,
  bgas_cfg_if.sink    cfg_i,
  bgas_res_if.source  res_o
);

  logic            push;
  logic            pop;
  logic            q_valid;
  bgas_pkg::job_t  push_job;
  bgas_pkg::job_t  head_job;

  bgas_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .cfg_i  (cfg_i),
    .pop_i  (pop),
    .push_o (push),
    .job_o  (push_job)
  );

  bgas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  bgas_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (head_job),
    .q_pop_o   (pop),
    .res_o     (res_o)
  );

endmodule

@@ test/bitplane_gradient_abs_sum_unit_tb.sv @@
// Self-checking testbench for the bit-plane L1 gradient block.
`timescale 1ns / 1ps

module bitplane_gradient_abs_sum_unit_tb;
  import bgas_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned IDLE_PAD    = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_PIXELS = 200;

  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } grad_word_t;

  // Line-buffer copy of the block plus the queue of gradient words it owes.
  class gradient_scoreboard;
    pix_t             upper_row  [PLANE_COUNT][MAX_WIDTH];
    pix_t             middle_row [PLANE_COUNT][MAX_WIDTH];
    pix_t             prev_px    [PLANE_COUNT];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    grad_word_t       owed_words [$];
    int unsigned      mismatches;
    int unsigned      words_checked;
    int unsigned      pixels;

    function new();
      for (int p = 0; p < PLANE_COUNT; p++) begin
        prev_px[p] = '0;
        for (int c = 0; c < MAX_WIDTH; c++) begin
          upper_row[p][c]  = '0;
          middle_row[p][c] = '0;
        end
      end
      col_cnt       = 0;
      row_cnt       = 0;
      width_reg     = FW_W'(FW_RESET);
      height_reg    = FH_W'(FH_RESET);
      mismatches    = 0;
      words_checked = 0;
      pixels        = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    endfunction

    function int unsigned absd(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    // A write restarts the frame; line contents stay.
    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
      else height_reg = value[FH_W-1:0];
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function void note_pixel(planes_t px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned acc;
      grad_word_t  word;
      w = eff_width();
      h = eff_height();
      c = (col_cnt >= w) ? w - 1 : col_cnt;
      r = (row_cnt >= h) ? h - 1 : row_cnt;
      pixels++;
      // Word for (r-1, c-1): row r-1 spans upper (left) and middle (right).
      if (r >= 2 && c >= 2) begin
        acc = 0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
          acc += absd(middle_row[p][c], upper_row[p][c-2]);
          acc += absd(prev_px[p], upper_row[p][c-1]);
        end
        word.sum = acc[SUM_W-1:0];
        word.row = ROW_W'(r - 1);
        word.col = OUT_COL_W'(c - 1);
        owed_words.push_back(word);
      end
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (c >= 1) begin
          upper_row[p][c-1]  = middle_row[p][c-1];
          middle_row[p][c-1] = prev_px[p];
        end
        if (c == w - 1) begin
          upper_row[p][c]  = middle_row[p][c];
          middle_row[p][c] = px[p];
        end
        prev_px[p] = px[p];
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
    endfunction

    function void check_word(logic [SUM_W-1:0] sum, logic [ROW_W-1:0] row,
                             logic [OUT_COL_W-1:0] col);
      grad_word_t exp_w;
      words_checked++;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word sum=%0d row=%0d col=%0d", $realtime, sum, row, col);
        return;
      end
      exp_w = owed_words.pop_front();
      if (sum !== exp_w.sum || row !== exp_w.row || col !== exp_w.col) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word mismatch exp sum=%0d row=%0d col=%0d, got sum=%0d row=%0d col=%0d",
                   $realtime, exp_w.sum, exp_w.row, exp_w.col, sum, row, col);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  bgas_pix_if pix_if ();
  bgas_cfg_if cfg_if ();
  bgas_res_if res_if ();

  bitplane_gradient_abs_sum_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  gradient_scoreboard sb;
  int          src_mode;
  int          res_mode;
  logic        res_hold;
  int unsigned settings;

  always #10 clk_i = ~clk_i;

  // Mode 0: no idling, 1: occasional gaps, 2: a gap drawn for every word.
  function automatic int unsigned draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic planes_t rand_pixel();
    planes_t px;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      case ($urandom_range(0, 9))
        0:       px[p] = '0;
        1:       px[p] = 16'h8000;
        2:       px[p] = 16'hFFFF;
        3:       px[p] = PIX_W'($urandom);
        default: px[p] = PIX_W'($urandom_range(0, 32768));
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(planes_t px);
    int unsigned gap;
    gap = draw_gap(src_mode);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.plane_0 <= px[0];
    pix_if.plane_1 <= px[1];
    pix_if.plane_2 <= px[2];
    pix_if.plane_3 <= px[3];
    pix_if.plane_4 <= px[4];
    pix_if.plane_5 <= px[5];
    pix_if.plane_6 <= px[6];
    pix_if.plane_7 <= px[7];
    do @(posedge clk_i); while (!pix_if.ready);
    sb.note_pixel(px);
  endtask

  // Drop valid and hold until every owed word has arrived.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(bit wr_w, logic [CFG_DATA_W-1:0] w, bit wr_h,
                           logic [CFG_DATA_W-1:0] h);
    wait_drained();
    repeat (IDLE_PAD) @(posedge clk_i);
    if (wr_w) write_reg(CFG_FRAME_WIDTH, w);
    if (wr_h) write_reg(CFG_FRAME_HEIGHT, h);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // 3x3 frame whose centre neighbours sit at the extremes of the plane range.
  task automatic send_cross(bit flip);
    pix_t hi;
    pix_t lo;
    pix_t v;
    hi = flip ? 16'h0000 : 16'hFFFF;
    lo = flip ? 16'hFFFF : 16'h0000;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 1 && c == 0) || (r == 0 && c == 1)) v = lo;
        else if ((r == 1 && c == 2) || (r == 2 && c == 1)) v = hi;
        else v = 16'h8000;
        send_pixel({PLANE_COUNT{v}});
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        sb.check_word(res_if.gradient_sum, res_if.out_row, res_if.out_col);
        stall = draw_gap(res_mode);
      end
      if (res_hold || stall != 0) begin
        res_if.ready <= 1'b0;
        if (stall != 0) stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words owed", cycles, sb.pending());
    $display("FAIL bitplane_gradient_abs_sum_unit");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_count;
    int unsigned n_items;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned sel;
    int unsigned wr_sel;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] h_data;

    sb             = new();
    settings       = 0;
    src_mode       = 0;
    res_mode       = 0;
    res_hold       = 1'b0;
    rst_ni         = 1'b0;
    pix_if.valid   = 1'b0;
    pix_if.plane_0 = '0;
    pix_if.plane_1 = '0;
    pix_if.plane_2 = '0;
    pix_if.plane_3 = '0;
    pix_if.plane_4 = '0;
    pix_if.plane_5 = '0;
    pix_if.plane_6 = '0;
    pix_if.plane_7 = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_FRAME_WIDTH;
    cfg_if.data    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, largest possible sum in both difference directions.
    src_mode = 2;
    res_mode = 2;
    configure(1'b1, 16'd3, 1'b1, 16'd3);
    send_cross(1'b0);
    // Undersized width and height both act as the minimum; run into the next frame.
    configure(1'b1, 16'd0, 1'b1, 16'd1);
    send_cross(1'b1);
    repeat (3) send_pixel(rand_pixel());

    // Stall the result side for a long stretch while pixels keep coming.
    src_mode = 0;
    res_mode = 1;
    configure(1'b1, 16'd8, 1'b1, 16'd5);
    fork
      begin
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        res_hold <= 1'b0;
      end
    join_none
    repeat (300) send_pixel(rand_pixel());

    // Widest frame, clamped from an all-ones width write; run past the first row end.
    src_mode = 1;
    res_mode = 1;
    configure(1'b1, 16'hFFFF, 1'b1, 16'd3);
    repeat (MAX_WIDTH + 4) send_pixel(rand_pixel());

    rand_count = 0;
    while (rand_count < RAND_PIXELS) begin
      sel    = $urandom_range(0, 9);
      w_data = {5'($urandom), 11'($urandom_range(3, 16))};
      h_data = CFG_DATA_W'($urandom_range(3, 8));
      if (sel == 0) w_data = {5'($urandom), 11'($urandom_range(0, 2))};
      if (sel == 1) h_data = CFG_DATA_W'($urandom_range(0, 2));
      if (sel == 2) h_data = CFG_DATA_W'($urandom);
      wr_sel   = (rand_count == 0) ? 3 : $urandom_range(1, 3);
      src_mode = $urandom_range(0, 2);
      res_mode = $urandom_range(0, 2);
      configure(wr_sel[0], w_data, wr_sel[1], h_data);
      w_eff = sb.eff_width();
      h_eff = sb.eff_height();
      if (h_eff <= 8)
        n_items = $urandom_range(1, 3) * w_eff * h_eff + $urandom_range(0, 2 * w_eff);
      else
        n_items = w_eff * $urandom_range(3, 10) + $urandom_range(0, w_eff);
      repeat (n_items) begin
        send_pixel(rand_pixel());
        rand_count++;
        if ($urandom_range(0, 79) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (IDLE_PAD) @(posedge clk_i);
    $display("Streamed %0d pixels over %0d frame settings, widths 3 to 1024 incl. clamping.",
             sb.pixels, settings);
    $display("Compared %0d gradient words, %0d mismatches.", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS bitplane_gradient_abs_sum_unit");
    end else begin
      $display("FAIL bitplane_gradient_abs_sum_unit");
    end
    $finish;
  end

endmodule
